/* hdl/huffman_table_encoder_core_assert.svh */
// assertion macros shared by the encoder core
`ifndef HUFFMAN_TABLE_ENCODER_CORE_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define HTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/hte_pkg.sv */
package hte_pkg;

    // operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD   = 2'd0;
    localparam t_op OP_ENCODE = 2'd1;
    localparam t_op OP_FLUSH  = 2'd2;

    // byte packing
    localparam int BYTE_BITS    = 8;
    localparam int PEND_BITS    = 7;
    localparam int PEND_CNT_W   = 3;

    // fixed field widths
    localparam int SYMBOL_W     = 8;
    localparam int CODE_BITS_W  = 32;
    localparam int CODE_LEN_W   = 6;
    localparam int OUT_TOTAL_W  = 32;

    // parameter defaults
    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int TOTAL_WIDTH_DEF  = 32;

endpackage

/* hdl/huffman_table_encoder_core.sv */
// Huffman table encoder with an LSB-first byte packer. Requests are load
// (write one code-table entry), encode (append a symbol's code, root-side bit
// first) and flush (emit the partial byte with the bit count, then clear).
// A request is taken every cycle while o_stall is low; encode and flush
// results pass through the stage one registers and the output group register.
// An encode that completes k bytes loads k results, drained one per cycle
// while i_stall is low; a following request with results stalls until the
// last is taken; loads and short codes yield none and skip that wait.
// The code table is a single-port memory read with registered data; entries
// read before being loaded return undefined codes.
`include "huffman_table_encoder_core_assert.svh"

module huffman_table_encoder_core
    import hte_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int TOTAL_WIDTH  = TOTAL_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_operation,
    input  logic [SYMBOL_W-1:0]    i_symbol,
    input  logic [CODE_BITS_W-1:0] i_code_bits,
    input  logic [CODE_LEN_W-1:0]  i_code_len,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [BYTE_BITS-1:0]   o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_last,
    output logic [OUT_TOTAL_W-1:0] o_total_bits
);

    localparam int ADDR_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ENT_W  = MAX_CODE_LEN + LEN_W;
    localparam int CB_W   = MAX_CODE_LEN + PEND_BITS;
    localparam int N_RES  = (MAX_CODE_LEN + PEND_BITS) / BYTE_BITS;
    localparam int CNT_W  = $clog2(N_RES + 1);
    localparam int SUM_W  = $clog2(CB_W + 1);

    // code table
    logic [ENT_W-1:0] r_table [SYMBOL_COUNT];

    logic                    in_acc;
    logic                    in_range;
    logic [LEN_W-1:0]        len_sat;
    logic [MAX_CODE_LEN-1:0] rd_pat;
    logic [LEN_W-1:0]        rd_len;

    // stage one registers
    logic                    r_s1_v;
    t_op                     r_s1_op;
    logic                    r_s1_hit;
    logic [ENT_W-1:0]        r_rd;

    // packer state
    logic [PEND_BITS-1:0]    r_pbits, n_pbits;
    logic [PEND_CNT_W-1:0]   r_pcnt, n_pcnt;
    logic [TOTAL_WIDTH-1:0]  r_total, n_total;

    // output group register
    logic [CNT_W-1:0]        r_g_cnt;
    logic [BYTE_BITS-1:0]    r_g_byte  [N_RES];
    logic [TOTAL_WIDTH-1:0]  r_g_tot   [N_RES];
    logic                    r_g_bv;
    logic                    r_g_last;

    logic                    out_acc;
    logic                    grp_free;
    logic                    s1_adv;
    logic [CNT_W-1:0]        n_res;
    logic [LEN_W-1:0]        eff_len;
    logic [MAX_CODE_LEN-1:0] rev_full;
    logic [MAX_CODE_LEN-1:0] rev;
    logic [CB_W-1:0]         comb_bits;
    logic [CB_W-1:0]         rest_bits;
    logic [SUM_W-1:0]        sum;

    // request side
    assign in_acc   = i_valid && !o_stall;
    assign in_range = ({1'b0, i_symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
    assign len_sat  = (i_code_len > CODE_LEN_W'(MAX_CODE_LEN)) ?
                      LEN_W'(MAX_CODE_LEN) : LEN_W'(i_code_len);

    // table write on load, registered read on every request
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == OP_LOAD && in_range) begin
            r_table[i_symbol[ADDR_W-1:0]] <= {i_code_bits[MAX_CODE_LEN-1:0], len_sat};
        end
        if (in_acc) begin
            r_rd <= r_table[i_symbol[ADDR_W-1:0]];
        end
    end

    // stage one control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_acc && (i_operation == OP_ENCODE || i_operation == OP_FLUSH)) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= i_operation;
            r_s1_hit <= (i_operation == OP_ENCODE) && in_range;
        end
    end

    assign rd_pat  = r_rd[ENT_W-1:LEN_W];
    assign rd_len  = r_rd[LEN_W-1:0];
    assign eff_len = r_s1_hit ? rd_len : '0;

    // reverse code so the root-side bit lands first
    always_comb begin
        for (int j = 0; j < MAX_CODE_LEN; j++) begin
            rev_full[j] = rd_pat[MAX_CODE_LEN-1-j];
        end
    end

    assign rev       = rev_full >> (LEN_W'(MAX_CODE_LEN) - eff_len);
    assign comb_bits = CB_W'(r_pbits) | (CB_W'(rev) << r_pcnt);
    assign sum       = SUM_W'(r_pcnt) + SUM_W'(eff_len);
    assign rest_bits = comb_bits >> {sum[SUM_W-1:3], 3'b000};

    // results this item produces
    always_comb begin
        if (r_s1_op == OP_FLUSH) begin
            n_res = CNT_W'(1);
        end else begin
            n_res = CNT_W'(sum >> 3);
        end
    end

    // output drain and advance control
    assign out_acc  = o_valid && !i_stall;
    assign grp_free = (r_g_cnt == '0) || (r_g_cnt == CNT_W'(1) && out_acc);
    assign s1_adv   = r_s1_v && ((n_res == '0) || grp_free);
    assign o_stall  = r_s1_v && !s1_adv;

    // next packer state
    always_comb begin
        n_pbits = r_pbits;
        n_pcnt  = r_pcnt;
        n_total = r_total;
        if (s1_adv) begin
            if (r_s1_op == OP_FLUSH) begin
                n_pbits = '0;
                n_pcnt  = '0;
                n_total = '0;
            end else begin
                n_pbits = rest_bits[PEND_BITS-1:0];
                n_pcnt  = sum[PEND_CNT_W-1:0];
                n_total = r_total + TOTAL_WIDTH'(eff_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
            r_total <= '0;
        end else begin
            r_pbits <= n_pbits;
            r_pcnt  <= n_pcnt;
            r_total <= n_total;
        end
    end

    // group count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_cnt <= '0;
        end else if (s1_adv && n_res != '0) begin
            r_g_cnt <= n_res;
        end else if (out_acc) begin
            r_g_cnt <= r_g_cnt - CNT_W'(1);
        end
    end

    // group payload: load a fresh group or shift toward entry zero
    always_ff @(posedge i_clk) begin
        if (s1_adv && n_res != '0) begin
            if (r_s1_op == OP_FLUSH) begin
                r_g_byte[0] <= (r_pcnt != '0) ? BYTE_BITS'(r_pbits) : '0;
                r_g_tot[0]  <= r_total;
                r_g_bv      <= (r_pcnt != '0);
                r_g_last    <= 1'b1;
            end else begin
                for (int k = 0; k < N_RES; k++) begin
                    r_g_byte[k] <= comb_bits[k*BYTE_BITS +: BYTE_BITS];
                    r_g_tot[k]  <= r_total + TOTAL_WIDTH'((k + 1) * BYTE_BITS)
                                   - TOTAL_WIDTH'(r_pcnt);
                end
                r_g_bv   <= 1'b1;
                r_g_last <= 1'b0;
            end
        end else if (out_acc) begin
            for (int k = 0; k < N_RES - 1; k++) begin
                r_g_byte[k] <= r_g_byte[k+1];
                r_g_tot[k]  <= r_g_tot[k+1];
            end
        end
    end

    // result outputs
    assign o_valid      = (r_g_cnt != '0);
    assign o_out_byte   = r_g_byte[0];
    assign o_byte_valid = r_g_bv;
    assign o_last       = r_g_last;
    assign o_total_bits = OUT_TOTAL_W'(r_g_tot[0]);

    // checks
    `HTE_ASSERT_NOW(a_grp_bound, 1'b1, r_g_cnt <= CNT_W'(N_RES), "group count too large")
    `HTE_ASSERT_NOW(a_stall_src, o_stall, r_s1_v && n_res != '0, "stall without pending results")
    `HTE_ASSERT_NOW(a_last_single, o_valid && o_last, r_g_cnt == CNT_W'(1), "flush result not alone")
    `HTE_ASSERT_NEXT(a_drain_end, out_acc && r_g_cnt == CNT_W'(1) && !s1_adv, !o_valid, "result repeated")
    `HTE_ASSERT_NEXT(a_flush_clr, s1_adv && r_s1_op == OP_FLUSH, r_pcnt == '0 && r_total == '0, "flush left state")

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hte_pkg::*;

    // operation code outside the defined set, must be ignored
    localparam t_op OP_IGNORED = 2'd3;

    localparam int HOLD_CYCLES    = 150;
    localparam int MISMATCH_SHOWN = 10;

    typedef struct packed {
        logic [BYTE_BITS-1:0]   out_byte;
        logic                   byte_valid;
        logic                   last;
        logic [OUT_TOTAL_W-1:0] total_bits;
    } t_byte_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [1:0]             i_operation;
    logic [SYMBOL_W-1:0]    i_symbol;
    logic [CODE_BITS_W-1:0] i_code_bits;
    logic [CODE_LEN_W-1:0]  i_code_len;
    logic                   o_valid;
    logic                   i_stall;
    logic [BYTE_BITS-1:0]   o_out_byte;
    logic                   o_byte_valid;
    logic                   o_last;
    logic [OUT_TOTAL_W-1:0] o_total_bits;

    // shadow of the encoder state
    logic [CODE_BITS_W-1:0] code_pat_tab [SYMBOL_COUNT_DEF];
    logic [CODE_LEN_W-1:0]  code_len_tab [SYMBOL_COUNT_DEF];
    bit                     is_loaded    [SYMBOL_COUNT_DEF];
    logic [SYMBOL_W-1:0]    loaded_syms[$];
    logic [BYTE_BITS-1:0]   pend_bits;
    int                     pend_cnt;
    logic [OUT_TOTAL_W-1:0] bit_total;

    t_byte_result packed_bytes_q[$];
    int           mismatch_count;
    bit           idle_on;
    bit           hold_req;

    huffman_table_encoder_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_symbol     (i_symbol),
        .i_code_bits  (i_code_bits),
        .i_code_len   (i_code_len),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_total_bits (o_total_bits)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_500_000;
        $display("tb: errors");
        $finish;
    end

    // apply one accepted request to the shadow state, queue the bytes it yields
    function automatic void pack_request(t_op op, logic [SYMBOL_W-1:0] sym,
                                         logic [CODE_BITS_W-1:0] bits,
                                         logic [CODE_LEN_W-1:0] len);
        int           n;
        t_byte_result r;
        case (op)
            OP_LOAD: begin
                // lengths past the maximum saturate
                code_pat_tab[sym] = bits;
                code_len_tab[sym] = (len > 6'd32) ? 6'd32 : len;
                if (!is_loaded[sym]) begin
                    is_loaded[sym] = 1'b1;
                    loaded_syms = {loaded_syms, sym};
                end
            end
            OP_ENCODE: begin
                // root-side bit first, lsb-first packing
                for (n = int'(code_len_tab[sym]); n > 0; n--) begin
                    pend_bits[pend_cnt] = code_pat_tab[sym][n-1];
                    pend_cnt++;
                    bit_total++;
                    if (pend_cnt == BYTE_BITS) begin
                        r.out_byte   = pend_bits;
                        r.byte_valid = 1'b1;
                        r.last       = 1'b0;
                        r.total_bits = bit_total;
                        packed_bytes_q = {packed_bytes_q, r};
                        pend_bits = '0;
                        pend_cnt  = 0;
                    end
                end
            end
            OP_FLUSH: begin
                r.out_byte   = (pend_cnt != 0) ? pend_bits : '0;
                r.byte_valid = (pend_cnt != 0);
                r.last       = 1'b1;
                r.total_bits = bit_total;
                packed_bytes_q = {packed_bytes_q, r};
                pend_bits = '0;
                pend_cnt  = 0;
                bit_total = '0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_SHOWN) begin
                $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
            end
        end
    endfunction

    // offer one request, hold it until taken
    task automatic send_request(t_op op, logic [SYMBOL_W-1:0] sym,
                                logic [CODE_BITS_W-1:0] bits,
                                logic [CODE_LEN_W-1:0] len);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_symbol    <= sym;
        i_code_bits <= bits;
        i_code_len  <= len;
        do @(posedge i_clk); while (o_stall);
        pack_request(op, sym, bits, len);
    endtask

    // encode of a symbol that has a table entry, other fields are noise
    task automatic send_random_encode();
        logic [SYMBOL_W-1:0] sym;
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_request(OP_ENCODE, sym, $urandom, 6'($urandom));
    endtask

    task automatic send_random_request();
        int                    pick;
        logic [CODE_LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            // mostly legal lengths, some unused, some overlong
            case ($urandom_range(0, 9))
                0: len = 6'd0;
                1: len = 6'($urandom_range(33, 63));
                default: len = 6'($urandom_range(1, 32));
            endcase
            send_request(OP_LOAD, 8'($urandom_range(0, 255)), $urandom, len);
        end else if (pick < 85) begin
            send_random_encode();
        end else if (pick < 96) begin
            send_request(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
        end else begin
            send_request(OP_IGNORED, 8'($urandom), $urandom, 6'($urandom));
        end
    endtask

    // flush with nothing pending, right after reset and back to back
    task automatic test_empty_flush();
        send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        send_request(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    endtask

    // shortest and longest codes, partial byte on flush
    task automatic test_code_extremes();
        send_request(OP_LOAD, 8'h00, 32'h0000_0000, 6'd1);
        send_request(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_request(OP_LOAD, 8'hAA, 32'h0000_0055, 6'd7);
        send_request(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        send_request(OP_ENCODE, 8'h00, 32'h0, 6'd0);
        send_request(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_request(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
        send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
        send_request(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    endtask

    // unused symbol, saturated lengths, pattern bits above the length
    task automatic test_unused_and_overlong();
        send_request(OP_LOAD, 8'h01, 32'hDEAD_BEEF, 6'd0);
        send_request(OP_ENCODE, 8'h01, 32'h0, 6'd0);
        send_request(OP_LOAD, 8'h02, 32'hA5A5_5A5A, 6'd63);
        send_request(OP_LOAD, 8'h03, 32'hFFFF_FF96, 6'd8);
        send_request(OP_LOAD, 8'h04, 32'h8000_0001, 6'd33);
        send_request(OP_ENCODE, 8'h02, 32'h0, 6'd0);
        send_request(OP_ENCODE, 8'h03, 32'h0, 6'd0);
        send_request(OP_ENCODE, 8'h04, 32'h0, 6'd0);
        send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    endtask

    // undefined operation between real ones
    task automatic test_unknown_op();
        send_request(OP_IGNORED, 8'h03, 32'hFFFF_FFFF, 6'h3F);
        send_request(OP_ENCODE, 8'h03, 32'h0, 6'd0);
        send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    endtask

    // receiver holds off while four-byte codes keep coming
    task automatic test_backpressure();
        int k;
        hold_req = 1'b1;
        for (k = 0; k < 16; k++) begin
            send_request(OP_ENCODE, 8'hFF, $urandom, 6'($urandom));
        end
        send_request(OP_FLUSH, 8'h00, 32'h0, 6'd0);
    endtask

    task automatic test_random_mix(int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_random_request();
        end
    endtask

    // stimulus
    initial begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        pend_bits      = '0;
        pend_cnt       = 0;
        bit_total      = '0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_LOAD;
        i_symbol    <= '0;
        i_code_bits <= '0;
        i_code_len  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_flush();
        test_code_extremes();
        test_unused_and_overlong();
        test_unknown_op();
        test_backpressure();
        test_random_mix(125);
        // last part with no idling on either side
        idle_on = 1'b0;
        test_random_mix(45);
        i_valid <= 1'b0;

        while (packed_bytes_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && packed_bytes_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // receiver stall: random bursts plus one long hold-off on request
    initial begin
        int burst;
        int hold;
        burst = 0;
        hold  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 18) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // compare each taken result with the oldest queued byte
    always @(posedge i_clk) begin : byte_checker
        t_byte_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (packed_bytes_q.size() == 0) begin
                check_field("unexpected result", 32'h0, {24'h0, o_out_byte} | 32'h100);
            end else begin
                want = packed_bytes_q.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(o_out_byte));
                check_field("byte_valid", 32'(want.byte_valid), 32'(o_byte_valid));
                check_field("last", 32'(want.last), 32'(o_last));
                check_field("total_bits", want.total_bits, o_total_bits);
            end
        end
    end

endmodule

/* files.f */
+incdir+hdl
hdl/hte_pkg.sv
hdl/huffman_table_encoder_core.sv
sim/tb.sv
